@@ design/btid_pkg.sv @@
// shared widths, limits and helpers for the terminator-block integer decoder
package btid_pkg;

	localparam int WordW       = 32;
	localparam int ValueW      = 32;
	localparam int BufW        = 35;
	localparam int BitsW       = 6;
	localparam int CfgW        = 3;
	localparam int NumWidthReg = 4;
	localparam int AddrW       = 4;
	localparam int DataW       = 32;
	localparam int MaxBlocks   = 16;

	localparam logic [CfgW-1:0] WidthReset = 3'd2;
	localparam logic [CfgW-1:0] WidthMin   = 3'd2;
	localparam logic [CfgW-1:0] WidthMax   = 3'd4;

	// pending result before the last-of-word flag is known
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              too_long;
	} result_t;

	function automatic logic [CfgW-1:0] clamp_width(input logic [CfgW-1:0] w);
		logic [CfgW-1:0] r;
		r = w;
		if (w < WidthMin) r = WidthMin;
		if (w > WidthMax) r = WidthMax;
		return r;
	endfunction

endpackage

@@ design/btid_if.sv @@
// valid/ready channel interfaces for stream words and decoded results
interface btid_word_if;
	logic                      valid;
	logic                      ready;
	logic [btid_pkg::WordW-1:0] stream_word;
	logic                      first_word;

	modport source (output valid, output stream_word, output first_word, input ready);
	modport sink (input valid, input stream_word, input first_word, output ready);
endinterface

interface btid_result_if;
	logic                       valid;
	logic                       ready;
	logic [btid_pkg::ValueW-1:0] decoded_value;
	logic                       too_long;
	logic                       last_of_word;

	modport source (output valid, output decoded_value, output too_long, output last_of_word,
		input ready);
	modport sink (input valid, input decoded_value, input too_long, input last_of_word,
		output ready);
endinterface

@@ design/block_terminator_integer_decoder.sv @@
// terminator-block mixed-radix integer code decoder, one block per cycle unless a stalled output holds it
//
//  channel   dir   handshake        payload
//  words     in    valid/ready      stream_word[31:0], first_word
//  results   out   valid/ready      decoded_value[31:0], too_long, last_of_word
//  apb       in    psel/penable     width_block0..3 at byte address 4*i
//
// a word is accepted in the idle state; the shared multiply-accumulate step then
// decodes one block at a time, and a closing step returns to idle once fewer bits
// than the block width remain; a result waits in a holding register until the
// next result or the word's end sets its last flag, so a stalled output pauses
// the step loop
// reset clears the buffer, the partial code and restores all widths to 2
module block_terminator_integer_decoder #(
	parameter int MAX_BLOCKS = btid_pkg::MaxBlocks
) (
	input  logic                         clk,
	input  logic                         arst_n,
	btid_word_if.sink                    words,
	btid_result_if.source                results,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [btid_pkg::AddrW-1:0]   paddr,
	input  logic [btid_pkg::DataW-1:0]   pwdata,
	output logic [btid_pkg::DataW-1:0]   prdata,
	output logic                         pready
);

	localparam int IdxW = $clog2(MAX_BLOCKS);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                        state_q;
	logic [btid_pkg::CfgW-1:0]     width_q [btid_pkg::NumWidthReg];
	logic [btid_pkg::BufW-1:0]     buf_q;
	logic [btid_pkg::BitsW-1:0]    bits_q;
	logic [IdxW-1:0]               idx_q;
	logic [btid_pkg::ValueW-1:0]   sum_q;
	logic [btid_pkg::ValueW-1:0]   weight_q;
	logic [btid_pkg::ValueW-1:0]   count_q;
	logic                          pend_valid_q;
	btid_pkg::result_t             pend_q;
	logic                          out_valid_q;
	btid_pkg::result_t             out_q;
	logic                          out_last_q;

	logic [btid_pkg::CfgW-1:0]     cur_w;
	logic [3:0]                    mask;
	logic [3:0]                    blk;
	logic                          have;
	logic                          term;
	logic                          at_limit;
	logic                          gen;
	logic                          out_free;
	logic                          step_ok;
	logic                          finish;
	logic                          out_load;
	logic [btid_pkg::ValueW-1:0]   prod;
	logic [btid_pkg::ValueW-1:0]   next_weight;
	logic                          cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = btid_pkg::DataW'(width_q[paddr[3:2]]);

	assign words.ready           = (state_q == ST_IDLE);
	assign results.valid         = out_valid_q;
	assign results.decoded_value = out_q.value;
	assign results.too_long      = out_q.too_long;
	assign results.last_of_word  = out_last_q;

	always_comb begin
		if (idx_q >= IdxW'(4)) begin
			cur_w = btid_pkg::WidthMin;
		end else begin
			cur_w = btid_pkg::clamp_width(width_q[idx_q[1:0]]);
		end
		mask        = 4'((5'd1 << cur_w) - 5'd1);
		blk         = buf_q[3:0] & mask;
		have        = bits_q >= btid_pkg::BitsW'(cur_w);
		term        = (blk == mask);
		at_limit    = (idx_q == IdxW'(MAX_BLOCKS - 1));
		gen         = have && (term || at_limit);
		out_free    = !out_valid_q || results.ready;
		step_ok     = have && (!gen || !pend_valid_q || out_free);
		finish      = !have && (!pend_valid_q || out_free);
		out_load    = (state_q == ST_RUN) && pend_valid_q && ((step_ok && gen) || finish);
		prod        = weight_q * btid_pkg::ValueW'(blk);
		next_weight = weight_q * btid_pkg::ValueW'(mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			for (int i = 0; i < btid_pkg::NumWidthReg; i++) begin
				width_q[i] <= btid_pkg::WidthReset;
			end
			buf_q        <= '0;
			bits_q       <= '0;
			idx_q        <= '0;
			sum_q        <= '0;
			weight_q     <= btid_pkg::ValueW'(1);
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				width_q[paddr[3:2]] <= pwdata[btid_pkg::CfgW-1:0];
			end
			out_valid_q <= out_load || (out_valid_q && !results.ready);
			unique case (state_q)
				ST_IDLE: begin
					if (words.valid) begin
						if (words.first_word) begin
							buf_q    <= btid_pkg::BufW'(words.stream_word);
							bits_q   <= btid_pkg::BitsW'(btid_pkg::WordW);
							idx_q    <= '0;
							sum_q    <= '0;
							weight_q <= btid_pkg::ValueW'(1);
							count_q  <= '0;
						end else begin
							buf_q  <= buf_q | (btid_pkg::BufW'(words.stream_word) << bits_q);
							bits_q <= bits_q + btid_pkg::BitsW'(btid_pkg::WordW);
						end
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (step_ok) begin
						buf_q  <= buf_q >> cur_w;
						bits_q <= bits_q - btid_pkg::BitsW'(cur_w);
						if (gen) begin
							idx_q    <= '0;
							sum_q    <= '0;
							weight_q <= btid_pkg::ValueW'(1);
							count_q  <= '0;
							if (pend_valid_q) begin
								out_q      <= pend_q;
								out_last_q <= 1'b0;
							end
							pend_valid_q    <= 1'b1;
							pend_q.value    <= term ? (sum_q + count_q) : '0;
							pend_q.too_long <= !term;
						end else begin
							sum_q    <= sum_q + prod;
							count_q  <= count_q + weight_q;
							weight_q <= next_weight;
							idx_q    <= idx_q + IdxW'(1);
						end
					end else if (finish) begin
						if (pend_valid_q) begin
							out_q      <= pend_q;
							out_last_q <= 1'b1;
						end
						pend_valid_q <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		words.ready |-> !pend_valid_q)
		else $error("pending result while idle");
	a_idle_leftover: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (bits_q < btid_pkg::BitsW'(4)))
		else $error("too many leftover bits while idle");
	a_buf_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= btid_pkg::BitsW'(btid_pkg::BufW))
		else $error("bit count exceeds buffer");
	a_accept_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(words.valid && words.ready) |=> (state_q == ST_RUN))
		else $error("accepted word not processed");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IdxW'(MAX_BLOCKS - 1))
		else $error("block index past limit");
`endif

endmodule
